>>> rtl/cmrh_pkg.sv
// Shared types and constants of the color matrix and histogram block.
package cmrh_pkg;

  localparam int CHAN_W      = 16;
  localparam int NUM_CHAN    = 4;
  localparam int NUM_LANES   = 3;
  localparam int COEFF_W     = 16;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int BIN_FIELD_W = 13;
  localparam int BIN_COUNT_W = 24;
  localparam int BIN_SHIFT   = 3;

  localparam logic ACT_READ_BIN = 1'b1;

  localparam logic [1:0] HCH_RED   = 2'd0;
  localparam logic [1:0] HCH_GREEN = 2'd1;
  localparam logic [1:0] HCH_BLUE  = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_COLORS  = 3'd0,
    REG_USE_MATRIX  = 3'd1,
    REG_FILTER_GRAY = 3'd2,
    REG_OUT_CEILING = 3'd3,
    REG_COEFF_RED   = 3'd4,
    REG_COEFF_GREEN = 3'd5,
    REG_COEFF_BLUE  = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic                   action;
    logic [CHAN_W-1:0]      chan0;
    logic [CHAN_W-1:0]      chan1;
    logic [CHAN_W-1:0]      chan2;
    logic [CHAN_W-1:0]      chan3;
    logic [1:0]             cfa_color;
    logic [1:0]             bin_channel;
    logic [BIN_FIELD_W-1:0] bin_index;
  } pixel_t;

  typedef struct packed {
    logic [CHAN_W-1:0]      red;
    logic [CHAN_W-1:0]      green;
    logic [CHAN_W-1:0]      blue;
    logic [BIN_COUNT_W-1:0] bin_count;
  } result_t;

  typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] chan_vec_t;

  typedef struct packed {
    logic                use_mat;
    logic [NUM_CHAN-1:0] mask;
  } lane_ctrl_t;

  typedef struct packed {
    logic                   valid;
    logic                   incr;
    logic [BIN_FIELD_W-1:0] bin;
  } hist_req_t;

endpackage

>>> rtl/color_matrix_rgb_histogram.sv
// Top level: configuration, pixel preprocessing, three color lanes, histograms and output queue.
//
//   channel  | signals                                  | transfer when
//   ---------+------------------------------------------+-------------------------------
//   pixel    | pixel_valid, pixel_stall, pixel          | pixel_valid && !pixel_stall
//   result   | result_valid, result_stall, result       | result_valid && !result_stall
//   config   | cfg_write, cfg_index, cfg_data           | cfg_write
//
// A pixel or bin read enters every cycle that pixel_stall is low; its result passes the input
// register, the two multiply and sum stages and the histogram read-modify-write to the queue.
// After reset, each histogram memory is cleared one bin per cycle, and pixel_stall stays high
// until every bin is cleared. An eight-entry output queue holds finished results, and
// pixel_stall also rises when results in flight and queued could fill it.
module color_matrix_rgb_histogram #(
  parameter int HIST_BINS       = 8192,
  parameter int COUNT_BITS      = 24,
  parameter int COEFF_FRAC_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pixel_valid,
  output logic                          pixel_stall,
  input  cmrh_pkg::pixel_t              pixel,
  output logic                          result_valid,
  input  logic                          result_stall,
  output cmrh_pkg::result_t             result,
  input  logic                          cfg_write,
  input  logic [cmrh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cmrh_pkg::CFG_W-1:0]    cfg_data
);
  import cmrh_pkg::*;

  localparam int Q_DEPTH = 8;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = Q_PTR_W + 1;
  localparam logic [BIN_FIELD_W-1:0] LAST_BIN = BIN_FIELD_W'(HIST_BINS - 1);

  logic [2:0]        num_colors;
  logic              use_matrix;
  logic              filter_gray;
  logic [CHAN_W-1:0] out_ceiling;
  logic [CFG_W-1:0]  coeff_row [NUM_LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      num_colors   <= 3'd3;
      use_matrix   <= 1'b0;
      filter_gray  <= 1'b0;
      out_ceiling  <= '1;
      coeff_row[0] <= '0;
      coeff_row[1] <= '0;
      coeff_row[2] <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_NUM_COLORS:  num_colors   <= cfg_data[2:0];
        REG_USE_MATRIX:  use_matrix   <= cfg_data[0];
        REG_FILTER_GRAY: filter_gray  <= cfg_data[0];
        REG_OUT_CEILING: out_ceiling  <= cfg_data[CHAN_W-1:0];
        REG_COEFF_RED:   coeff_row[0] <= cfg_data;
        REG_COEFF_GREEN: coeff_row[1] <= cfg_data;
        REG_COEFF_BLUE:  coeff_row[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  logic                   accept;
  logic                   v0, v1, v2, v3;
  pixel_t                 item0;
  logic                   act1, act2, act3;
  logic [1:0]             bch1, bch2, bch3;
  logic [BIN_FIELD_W-1:0] bidx1, bidx2;
  logic                   oob3;
  logic [CHAN_W-1:0]      rgb3 [NUM_LANES];

  assign accept = pixel_valid && !pixel_stall;

  always_ff @(posedge clk) begin
    item0 <= pixel;
    act1  <= item0.action;
    bch1  <= item0.bin_channel;
    bidx1 <= item0.bin_index;
    act2  <= act1;
    bch2  <= bch1;
    bidx2 <= bidx1;
    act3  <= act2;
    bch3  <= bch2;
    oob3  <= bidx2 > LAST_BIN;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v0 <= accept;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Channel preprocessing shared by the lanes.
  logic [2:0]          colors;
  logic                gray;
  logic [CHAN_W:0]     green_sum;
  chan_vec_t           chans;
  logic [CHAN_W-1:0]   gray_val;
  lane_ctrl_t          ctrl;
  logic [CHAN_W-1:0]   copy_val [NUM_LANES];

  always_comb begin
    if (filter_gray) begin
      colors = 3'd1;
    end else if (num_colors > 3'd4) begin
      colors = 3'd4;
    end else begin
      colors = num_colors;
    end
    gray      = colors == 3'd1;
    green_sum = {1'b0, item0.chan1} + {1'b0, item0.chan3};
    chans[0]  = item0.chan0;
    chans[1]  = (colors == 3'd4 && !use_matrix) ? green_sum[CHAN_W:1] : item0.chan1;
    chans[2]  = item0.chan2;
    chans[3]  = item0.chan3;
    gray_val  = filter_gray ? chans[item0.cfa_color] : chans[0];
    ctrl.use_mat = use_matrix && !gray;
    for (int j = 0; j < NUM_CHAN; j++) begin
      ctrl.mask[j] = 3'(j) < colors;
    end
    for (int i = 0; i < NUM_LANES; i++) begin
      copy_val[i] = gray ? gray_val : chans[i];
    end
  end

  logic [CHAN_W-1:0]     res2 [NUM_LANES];
  logic [COUNT_BITS-1:0] hcount [NUM_LANES];
  logic [NUM_LANES-1:0]  hbusy;
  hist_req_t             hreq [NUM_LANES];

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    logic [BIN_FIELD_W-1:0] pix_bin;

    cmrh_lane #(
      .FRAC_BITS (COEFF_FRAC_BITS)
    ) u_lane (
      .clk       (clk),
      .chans     (chans),
      .coeff_row (coeff_row[i]),
      .ctrl      (ctrl),
      .copy_val  (copy_val[i]),
      .ceiling   (out_ceiling),
      .res       (res2[i])
    );

    assign pix_bin = res2[i][CHAN_W-1:BIN_SHIFT];

    always_comb begin
      hreq[i].valid = v2;
      hreq[i].incr  = act2 != ACT_READ_BIN;
      if (act2 == ACT_READ_BIN) begin
        hreq[i].bin = bidx2;
      end else begin
        hreq[i].bin = (pix_bin > LAST_BIN) ? LAST_BIN : pix_bin;
      end
    end

    cmrh_hist #(
      .HIST_BINS  (HIST_BINS),
      .COUNT_BITS (COUNT_BITS)
    ) u_hist (
      .clk   (clk),
      .rst   (rst),
      .req   (hreq[i]),
      .count (hcount[i]),
      .busy  (hbusy[i])
    );

    always_ff @(posedge clk) begin
      rgb3[i] <= res2[i];
    end
  end

  // Form one result: the lane results for a pixel, or the selected bin count for a bin read.
  logic [COUNT_BITS-1:0] count_sel;
  result_t               merged;

  always_comb begin
    case (bch3)
      HCH_RED:   count_sel = hcount[0];
      HCH_GREEN: count_sel = hcount[1];
      HCH_BLUE:  count_sel = hcount[2];
      default:   count_sel = '0;
    endcase
    if (oob3) begin
      count_sel = '0;
    end
    if (act3 == ACT_READ_BIN) begin
      merged.red       = '0;
      merged.green     = '0;
      merged.blue      = '0;
      merged.bin_count = BIN_COUNT_W'(count_sel);
    end else begin
      merged.red       = rgb3[0];
      merged.green     = rgb3[1];
      merged.blue      = rgb3[2];
      merged.bin_count = '0;
    end
  end

  // Output queue.
  result_t              q_mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]   q_wr;
  logic [Q_PTR_W-1:0]   q_rd;
  logic [Q_CNT_W-1:0]   q_cnt;
  logic                 q_pop;
  logic [Q_CNT_W-1:0]   in_flight;

  assign result_valid = q_cnt != '0;
  assign result       = q_mem[q_rd];
  assign q_pop        = result_valid && !result_stall;
  assign in_flight    = Q_CNT_W'(v0) + Q_CNT_W'(v1) + Q_CNT_W'(v2) + Q_CNT_W'(v3);
  assign pixel_stall  = (|hbusy) || (in_flight + q_cnt >= Q_CNT_W'(Q_DEPTH));

  always_ff @(posedge clk) begin
    if (v3) begin
      q_mem[q_wr] <= merged;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr  <= '0;
      q_rd  <= '0;
      q_cnt <= '0;
    end else begin
      if (v3) begin
        q_wr <= q_wr + 1'b1;
      end
      if (q_pop) begin
        q_rd <= q_rd + 1'b1;
      end
      q_cnt <= q_cnt + Q_CNT_W'(v3) - Q_CNT_W'(q_pop);
    end
  end

  a_q_bound: assert property (@(posedge clk) disable iff (rst)
    q_cnt + in_flight <= Q_CNT_W'(Q_DEPTH)) else $error("output queue overcommitted");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    v3 |-> (q_cnt < Q_CNT_W'(Q_DEPTH)) || q_pop) else $error("transfer into a full queue");

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (|hbusy) |-> !accept) else $error("pixel taken during histogram clearing");

endmodule

>>> rtl/cmrh_lane.sv
// One color lane: four registered products, sum, floor shift and clamp, or a clamped copy.
module cmrh_lane #(
  parameter int FRAC_BITS = 12
) (
  input  logic                       clk,
  input  cmrh_pkg::chan_vec_t        chans,
  input  logic [cmrh_pkg::CFG_W-1:0] coeff_row,
  input  cmrh_pkg::lane_ctrl_t       ctrl,
  input  logic [cmrh_pkg::CHAN_W-1:0] copy_val,
  input  logic [cmrh_pkg::CHAN_W-1:0] ceiling,
  output logic [cmrh_pkg::CHAN_W-1:0] res
);
  import cmrh_pkg::*;

  localparam int PROD_W = CHAN_W + COEFF_W + 1;
  localparam int SUM_W  = PROD_W + 2;

  logic signed [PROD_W-1:0] prod [NUM_CHAN];
  logic signed [PROD_W-1:0] prod1 [NUM_CHAN];
  logic                     use_mat1;
  logic [CHAN_W-1:0]        copy1;
  logic signed [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]         shifted;
  logic [CHAN_W-1:0]        res_next;

  always_comb begin
    for (int j = 0; j < NUM_CHAN; j++) begin
      prod[j] = $signed({1'b0, chans[j]}) * $signed(coeff_row[COEFF_W*j +: COEFF_W]);
      if (!ctrl.mask[j]) begin
        prod[j] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod1    <= prod;
    use_mat1 <= ctrl.use_mat;
    copy1    <= copy_val;
  end

  always_comb begin
    sum = '0;
    for (int j = 0; j < NUM_CHAN; j++) begin
      sum = sum + SUM_W'(prod1[j]);
    end
    shifted = $unsigned(sum) >> FRAC_BITS;
    if (use_mat1) begin
      if (sum[SUM_W-1]) begin
        res_next = '0;
      end else if (shifted > SUM_W'(ceiling)) begin
        res_next = ceiling;
      end else begin
        res_next = shifted[CHAN_W-1:0];
      end
    end else begin
      res_next = (copy1 > ceiling) ? ceiling : copy1;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

endmodule

>>> rtl/cmrh_hist.sv
// One histogram: counter memory with read-modify-write, forwarding and a clearing pass.
module cmrh_hist #(
  parameter int HIST_BINS  = 8192,
  parameter int COUNT_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmrh_pkg::hist_req_t   req,
  output logic [COUNT_BITS-1:0] count,
  output logic                  busy
);
  import cmrh_pkg::*;

  localparam int IDX_W = $clog2(HIST_BINS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HIST_BINS - 1);

  logic [COUNT_BITS-1:0] mem [HIST_BINS];
  logic [COUNT_BITS-1:0] rdata;
  logic [IDX_W-1:0]      clr_idx;
  logic                  valid3;
  logic                  incr3;
  logic [IDX_W-1:0]      idx3;
  logic                  fwd_valid;
  logic [IDX_W-1:0]      fwd_idx;
  logic [COUNT_BITS-1:0] fwd_data;
  logic [COUNT_BITS-1:0] cur;
  logic [COUNT_BITS-1:0] upd;
  logic                  we;

  // A write made in the cycle of this read is not yet in rdata.
  assign cur   = (fwd_valid && fwd_idx == idx3) ? fwd_data : rdata;
  assign upd   = (&cur) ? cur : cur + 1'b1;
  assign we    = valid3 && incr3;
  assign count = cur;

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_idx] <= '0;
    end else if (we) begin
      mem[idx3] <= upd;
    end
    rdata <= mem[req.bin[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    idx3     <= req.bin[IDX_W-1:0];
    incr3    <= req.incr;
    fwd_idx  <= idx3;
    fwd_data <= upd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b1;
      clr_idx   <= '0;
      valid3    <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      valid3    <= req.valid;
      fwd_valid <= we;
      if (busy) begin
        clr_idx <= clr_idx + 1'b1;
        if (clr_idx == LAST_IDX) begin
          busy <= 1'b0;
        end
      end
    end
  end

  a_clear_once: assert property (@(posedge clk) disable iff (rst)
    !busy |=> !busy) else $error("histogram clearing restarted without reset");

endmodule

>>> verif/tb_color_matrix_rgb_histogram.sv
// Self-checking testbench for the color matrix and histogram block.
module tb_color_matrix_rgb_histogram;
  timeunit 1ns;
  timeprecision 1ps;

  import cmrh_pkg::*;

  localparam int HIST_BINS       = 8192;
  localparam int COEFF_FRAC_BITS = 12;
  localparam int COUNT_MAX       = (1 << BIN_COUNT_W) - 1;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int PHASES          = 8;
  localparam int PHASE_ITEMS     = 78;
  localparam logic [1:0] HCH_NONE = 2'd3;

  typedef enum logic {ROW_REG, ROW_PIXEL} row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    cfg_reg_t         addr;
    logic [CFG_W-1:0] value;
    pixel_t           px;
    logic             typed;
    result_t          want;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 pixel_valid = 1'b0;
  logic                 pixel_stall;
  pixel_t               pixel = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  result_t              result;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  color_matrix_rgb_histogram dut (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #10 clk = ~clk;

  logic [2:0]        m_colors = 3'd3;
  logic              m_matrix = 1'b0;
  logic              m_doc = 1'b0;
  logic [CHAN_W-1:0] m_clip = 16'hFFFF;
  logic [CFG_W-1:0]  m_coeff [NUM_LANES] = '{default: '0};
  int unsigned       bin_counts [NUM_LANES][HIST_BINS];

  result_t     awaited_results [$];
  result_t     recent_pixels [$];
  pixel_t      last_pixel = '0;
  plan_row_t   directed_plan [$];
  bit          idle_on = 1'b1;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int          stall_left = 0;

  function automatic logic [CHAN_W-1:0] clip_level(longint v);
    if (v < 0) return '0;
    if (v > longint'(m_clip)) return m_clip;
    return v[CHAN_W-1:0];
  endfunction

  function automatic result_t convert_pixel(pixel_t p);
    logic [CHAN_W-1:0] ch [NUM_CHAN];
    logic [CHAN_W-1:0] lvl [NUM_LANES];
    logic [BIN_FIELD_W-1:0] bin;
    int colors;
    longint acc;
    result_t r;
    r = '0;
    if (p.action == ACT_READ_BIN) begin
      if (p.bin_channel != HCH_NONE) begin
        r.bin_count = bin_counts[p.bin_channel][p.bin_index][BIN_COUNT_W-1:0];
      end
      return r;
    end
    ch[0] = p.chan0;
    ch[1] = p.chan1;
    ch[2] = p.chan2;
    ch[3] = p.chan3;
    colors = m_doc ? 1 : int'(m_colors);
    if (colors > NUM_CHAN) colors = NUM_CHAN;
    if (colors == NUM_CHAN && !m_matrix) begin
      ch[1] = CHAN_W'((int'(ch[1]) + int'(ch[3])) >> 1);
    end
    for (int i = 0; i < NUM_LANES; i++) begin
      if (colors == 1) begin
        lvl[i] = clip_level(longint'(ch[m_doc ? int'(p.cfa_color) : 0]));
      end else if (m_matrix) begin
        acc = 0;
        for (int j = 0; j < colors; j++) begin
          acc += longint'(ch[j]) * longint'($signed(m_coeff[i][COEFF_W*j +: COEFF_W]));
        end
        lvl[i] = (acc < 0) ? '0 : clip_level(acc >>> COEFF_FRAC_BITS);
      end else begin
        lvl[i] = clip_level(longint'(ch[i]));
      end
      bin = lvl[i][CHAN_W-1:BIN_SHIFT];
      if (bin_counts[i][bin] < COUNT_MAX) bin_counts[i][bin]++;
    end
    r.red   = lvl[0];
    r.green = lvl[1];
    r.blue  = lvl[2];
    return r;
  endfunction

  function automatic void apply_reg(cfg_reg_t a, logic [CFG_W-1:0] v);
    case (a)
      REG_NUM_COLORS:  m_colors = v[2:0];
      REG_USE_MATRIX:  m_matrix = v[0];
      REG_FILTER_GRAY: m_doc = v[0];
      REG_OUT_CEILING: m_clip = v[CHAN_W-1:0];
      REG_COEFF_RED:   m_coeff[0] = v;
      REG_COEFF_GREEN: m_coeff[1] = v;
      REG_COEFF_BLUE:  m_coeff[2] = v;
      default: ;
    endcase
  endfunction

  function automatic pixel_t mk_px(logic [15:0] c0, logic [15:0] c1, logic [15:0] c2,
                                   logic [15:0] c3, logic [1:0] cfa);
    pixel_t p;
    p = '0;
    p.action = ~ACT_READ_BIN;
    p.chan0 = c0;
    p.chan1 = c1;
    p.chan2 = c2;
    p.chan3 = c3;
    p.cfa_color = cfa;
    return p;
  endfunction

  function automatic pixel_t mk_read(logic [1:0] lane, logic [BIN_FIELD_W-1:0] idx);
    pixel_t p;
    p = '0;
    p.action = ACT_READ_BIN;
    p.bin_channel = lane;
    p.bin_index = idx;
    return p;
  endfunction

  function automatic result_t mk_rgb(logic [15:0] r, logic [15:0] g, logic [15:0] b,
                                     logic [BIN_COUNT_W-1:0] cnt);
    result_t res;
    res.red = r;
    res.green = g;
    res.blue = b;
    res.bin_count = cnt;
    return res;
  endfunction

  function automatic void plan_reg(cfg_reg_t a, logic [CFG_W-1:0] v);
    plan_row_t row;
    row = '0;
    row.kind = ROW_REG;
    row.addr = a;
    row.value = v;
    directed_plan.push_back(row);
  endfunction

  function automatic void plan_px(pixel_t p, logic typed, result_t want);
    plan_row_t row;
    row = '0;
    row.kind = ROW_PIXEL;
    row.px = p;
    row.typed = typed;
    row.want = want;
    directed_plan.push_back(row);
  endfunction

  function automatic logic [CHAN_W-1:0] random_level();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 16'hFFFF;
      2: return CHAN_W'($urandom_range(0, 255));
      default: return CHAN_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] random_coeff_row();
    logic [CFG_W-1:0] row;
    for (int j = 0; j < NUM_CHAN; j++) begin
      case ($urandom_range(0, 5))
        0: row[COEFF_W*j +: COEFF_W] = 16'h1000;
        1: row[COEFF_W*j +: COEFF_W] = COEFF_W'($urandom_range(0, 16'h1FFF));
        2: row[COEFF_W*j +: COEFF_W] = -COEFF_W'($urandom_range(0, 16'h1000));
        3: row[COEFF_W*j +: COEFF_W] = COEFF_W'($urandom);
        4: row[COEFF_W*j +: COEFF_W] = 16'h7FFF;
        default: row[COEFF_W*j +: COEFF_W] = 16'h8000;
      endcase
    end
    return row;
  endfunction

  function automatic pixel_t random_item();
    pixel_t p;
    result_t seen;
    logic [95:0] raw;
    int k;
    raw = {$urandom, $urandom, $urandom};
    p = raw[$bits(pixel_t)-1:0];
    k = $urandom_range(0, 99);
    if (k < 15) begin
      p.action = ACT_READ_BIN;
      if (recent_pixels.size() != 0 && $urandom_range(0, 3) != 0) begin
        seen = recent_pixels[$urandom_range(0, recent_pixels.size() - 1)];
        case ($urandom_range(0, 2))
          0: begin
            p.bin_channel = HCH_RED;
            p.bin_index = seen.red[CHAN_W-1:BIN_SHIFT];
          end
          1: begin
            p.bin_channel = HCH_GREEN;
            p.bin_index = seen.green[CHAN_W-1:BIN_SHIFT];
          end
          default: begin
            p.bin_channel = HCH_BLUE;
            p.bin_index = seen.blue[CHAN_W-1:BIN_SHIFT];
          end
        endcase
      end
    end else if (k < 30) begin
      p = last_pixel;
    end else begin
      p.action = ~ACT_READ_BIN;
      p.chan0 = random_level();
      p.chan1 = random_level();
      p.chan2 = random_level();
      p.chan3 = random_level();
    end
    return p;
  endfunction

  function automatic void check_field(string name, logic [31:0] expv, logic [31:0] actv);
    if (expv !== actv) begin
      $error("%s: expected %0h, got %0h", name, expv, actv);
      mismatch_count++;
    end
  endfunction

  task automatic drain();
    pixel_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t a, logic [CFG_W-1:0] v);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= a;
    cfg_data <= v;
    apply_reg(a, v);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic push_pixel(pixel_t p, logic typed, result_t want);
    result_t predicted;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      pixel_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    pixel_valid <= 1'b1;
    pixel <= p;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    predicted = convert_pixel(p);
    awaited_results.push_back(typed ? want : predicted);
    if (p.action != ACT_READ_BIN) begin
      last_pixel = p;
      recent_pixels.push_back(predicted);
      if (recent_pixels.size() > 32) void'(recent_pixels.pop_front());
    end
    @(negedge clk);
  endtask

  task automatic randomize_setup();
    int k;
    int unsigned colors_sel;
    k = $urandom_range(0, 5);
    colors_sel = (k == 0) ? 1 : (k == 1) ? 3 : (k == 2) ? 4 : $urandom_range(0, 7);
    write_reg(REG_NUM_COLORS, CFG_W'(colors_sel));
    write_reg(REG_USE_MATRIX, CFG_W'($urandom_range(0, 1)));
    write_reg(REG_FILTER_GRAY, CFG_W'(($urandom_range(0, 3) == 0) ? 1 : 0));
    k = $urandom_range(0, 9);
    write_reg(REG_OUT_CEILING,
              CFG_W'((k == 0) ? 0 : (k < 5) ? 16'hFFFF : $urandom_range(0, 65535)));
    write_reg(REG_COEFF_RED, random_coeff_row());
    write_reg(REG_COEFF_GREEN, random_coeff_row());
    write_reg(REG_COEFF_BLUE, random_coeff_row());
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (result_stall) begin
      result_stall <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      result_stall <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (awaited_results.size() == 0) begin
        $error("result transfer with no pixel awaiting it");
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        check_field("red", 32'(want.red), 32'(result.red));
        check_field("green", 32'(want.green), 32'(result.green));
        check_field("blue", 32'(want.blue), 32'(result.blue));
        check_field("bin_count", 32'(want.bin_count), 32'(result.bin_count));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    plan_px(mk_read(HCH_RED, 0), 1'b1, mk_rgb(0, 0, 0, 0));
    plan_px(mk_read(HCH_NONE, 13'h1FFF), 1'b1, mk_rgb(0, 0, 0, 0));
    plan_px(mk_px(0, 0, 0, 0, 0), 1'b1, mk_rgb(0, 0, 0, 0));
    plan_px(mk_px(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3), 1'b1,
            mk_rgb(16'hFFFF, 16'hFFFF, 16'hFFFF, 0));
    plan_px(mk_px(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 2), 1'b1,
            mk_rgb(16'h1234, 16'h5678, 16'h9ABC, 0));
    plan_px(mk_read(HCH_RED, 0), 1'b1, mk_rgb(0, 0, 0, 1));
    plan_px(mk_read(HCH_BLUE, 13'h1FFF), 1'b1, mk_rgb(0, 0, 0, 1));
    plan_px(mk_read(HCH_GREEN, BIN_FIELD_W'(16'h5678 >> BIN_SHIFT)), 1'b1, mk_rgb(0, 0, 0, 1));
    plan_reg(REG_NUM_COLORS, 4);
    plan_px(mk_px(1, 16'hFFFF, 2, 16'hFFFF, 0), 1'b1, mk_rgb(1, 16'hFFFF, 2, 0));
    plan_px(mk_px(0, 1, 16'h8000, 2, 1), 1'b0, '0);
    plan_reg(REG_OUT_CEILING, 0);
    plan_px(mk_px(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0), 1'b1, mk_rgb(0, 0, 0, 0));
    plan_reg(REG_OUT_CEILING, 1000);
    plan_reg(REG_FILTER_GRAY, 1);
    for (int c = 0; c < 4; c++) plan_px(mk_px(100, 200, 300, 2000, 2'(c)), 1'b0, '0);
    plan_reg(REG_FILTER_GRAY, 0);
    plan_reg(REG_NUM_COLORS, 1);
    plan_reg(REG_OUT_CEILING, 64'hFFFF);
    plan_px(mk_px(16'hABCD, 1, 2, 3, 2), 1'b1, mk_rgb(16'hABCD, 16'hABCD, 16'hABCD, 0));
    plan_reg(REG_USE_MATRIX, 1);
    plan_px(mk_px(16'h4321, 5, 6, 7, 1), 1'b1, mk_rgb(16'h4321, 16'h4321, 16'h4321, 0));
    plan_reg(REG_NUM_COLORS, 3);
    plan_reg(REG_COEFF_RED, 64'h0000_0000_0000_1000);
    plan_reg(REG_COEFF_GREEN, 64'h0000_0000_F000_0000);
    plan_reg(REG_COEFF_BLUE, 64'h7FFF_7FFF_7FFF_7FFF);
    plan_px(mk_px(16'h1234, 16'h5678, 16'hFFFF, 16'hFFFF, 0), 1'b1,
            mk_rgb(16'h1234, 0, 16'hFFFF, 0));
    plan_px(mk_px(16'h8000, 16'h0123, 16'h0040, 16'h7777, 3), 1'b0, '0);
    plan_reg(REG_COEFF_GREEN, 64'h8000_8000_8000_8000);
    plan_px(mk_px(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1), 1'b1,
            mk_rgb(16'hFFFF, 0, 16'hFFFF, 0));
    plan_reg(REG_NUM_COLORS, 0);
    plan_px(mk_px(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2), 1'b1, mk_rgb(0, 0, 0, 0));
    plan_reg(REG_NUM_COLORS, 2);
    plan_px(mk_px(16'h0100, 16'h0200, 16'h0300, 16'h0400, 0), 1'b0, '0);
    plan_reg(REG_NUM_COLORS, 7);
    plan_px(mk_px(16'h2000, 16'h1000, 16'h0800, 16'h0400, 3), 1'b0, '0);
    plan_px(mk_read(HCH_GREEN, 0), 1'b0, '0);
    plan_px(mk_read(HCH_NONE, 5), 1'b1, mk_rgb(0, 0, 0, 0));
    plan_px(mk_read(HCH_BLUE, 13'h1FFF), 1'b0, '0);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_plan[n]) begin
      if (directed_plan[n].kind == ROW_REG) begin
        write_reg(directed_plan[n].addr, directed_plan[n].value);
      end else begin
        push_pixel(directed_plan[n].px, directed_plan[n].typed, directed_plan[n].want);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      idle_on = !(phase == 2 || phase == PHASES - 1);
      randomize_setup();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // In phase 4, let the pipeline and output queue run completely dry once mid-phase.
        if (phase == 4 && n == PHASE_ITEMS / 2) drain();
        push_pixel(random_item(), 1'b0, '0);
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
